### design/tilt_compensated_heading_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt compensated heading unit
// Concurrent checks, removed when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_HEADING_UNIT_MACROS_SVH
`define TILT_COMPENSATED_HEADING_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading unit check failed");
`define TCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading unit check failed");
`else
`define TCH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/tch_pkg.sv
// ----------------------------------------------------------------------------
// Heading unit package
// Widths, shared types, arctangent table and square root step.
// ----------------------------------------------------------------------------
package tch_pkg;

    localparam int AXIS_W           = 16;
    localparam int FIELD_W          = AXIS_W + 1;
    localparam int SQ_W             = 2 * AXIS_W;
    localparam int ROOT_W           = 16;
    localparam int HV_W             = 50;
    localparam int CX_W             = 34;
    localparam int ANG_W            = 32;
    localparam int HEAD_W           = 16;
    localparam int ATAN_LEN         = 24;
    localparam int IDX_W            = $clog2(ATAN_LEN);
    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic [HEAD_W-1:0] HEADING_FULL = 16'd46080;

    typedef struct packed {
        logic signed [AXIS_W-1:0] mag_x;
        logic signed [AXIS_W-1:0] mag_y;
        logic signed [AXIS_W-1:0] mag_z;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } t_req;

    typedef struct packed {
        logic signed [HV_W-1:0] xh;
        logic signed [HV_W-1:0] yh;
        logic                   acc_ok;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [SQ_W:0] v;
        logic [SQ_W:0] res;
    } t_sqs;

    function automatic logic [ANG_W-1:0] atan_turn(input logic [IDX_W-1:0] i);
        case (i)
            0:       return 32'd536870912;
            1:       return 32'd316933406;
            2:       return 32'd167458907;
            3:       return 32'd85004756;
            4:       return 32'd42667331;
            5:       return 32'd21354465;
            6:       return 32'd10679838;
            7:       return 32'd5340245;
            8:       return 32'd2670163;
            9:       return 32'd1335087;
            10:      return 32'd667544;
            11:      return 32'd333772;
            12:      return 32'd166886;
            13:      return 32'd83443;
            14:      return 32'd41722;
            15:      return 32'd20861;
            16:      return 32'd10430;
            17:      return 32'd5215;
            18:      return 32'd2608;
            19:      return 32'd1304;
            20:      return 32'd652;
            21:      return 32'd326;
            22:      return 32'd163;
            23:      return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

    function automatic t_sqs sqrt_step(input logic [SQ_W:0] v, input logic [SQ_W:0] res,
                                       input logic [SQ_W:0] bt);
        t_sqs          o;
        logic [SQ_W:0] t;
        t = res + bt;
        if (v >= t) begin
            o.v   = v - t;
            o.res = (res >> 1) + bt;
        end else begin
            o.v   = v;
            o.res = res >> 1;
        end
        return o;
    endfunction

endpackage

### design/tch_if.sv
// ----------------------------------------------------------------------------
// Heading unit channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tch_req_if;
    import tch_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] mag_x;
    logic signed [AXIS_W-1:0] mag_y;
    logic signed [AXIS_W-1:0] mag_z;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    modport source (output valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                    input ready);
    modport sink (input valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                  output ready);
endinterface

interface tch_res_if;
    import tch_pkg::*;
    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] heading;
    logic              heading_valid;
    modport source (output valid, heading, heading_valid, input ready);
    modport sink (input valid, heading, heading_valid, output ready);
endinterface

### design/tilt_compensated_heading_unit.sv
// ----------------------------------------------------------------------------
// Tilt compensated heading unit
// Compass heading in 1/128 degree from magnetometer and accelerometer triples.
// ----------------------------------------------------------------------------
// One request goes in, one result comes out, in order. The front end takes a
// request into a one-entry holding register, then works it through squaring,
// the two 16-step square root loops (one bit pair per cycle) and the products.
// The back end works on the previous request meanwhile: a pop, normalize
// shifts, CORDIC_STEPS rotation steps (at most 24), then mapping, scaling and
// output load. Requests with an all-zero accelerometer or a zero axis of the
// horizontal field skip normalize and rotation. A two-entry queue and an
// output register let both sides stall independently. An all-zero
// accelerometer gives heading_valid 0 and heading 0.
`include "tilt_compensated_heading_unit_macros.svh"

module tilt_compensated_heading_unit #(
    parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tch_req_if.sink   i_req,
    tch_res_if.source o_res
);
    import tch_pkg::*;

    t_q_stat  w_qstat;
    t_q_entry w_fentry, w_qentry;
    logic     w_push, w_pop;

    tch_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_fentry)
    );

    tch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_fentry),
        .i_pop   (w_pop),
        .o_entry (w_qentry),
        .o_qstat (w_qstat)
    );

    tch_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_entry (w_qentry),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    `TCH_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, o_res.valid && !o_res.heading_valid, o_res.heading == '0)
    `TCH_ASSERT_IMP(a_heading_range, i_clk, i_rst_n, o_res.valid, o_res.heading < HEADING_FULL)
    `TCH_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, w_push, !w_qstat.full)
    `TCH_ASSERT_NXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, !w_qstat.full)

endmodule

### design/tch_front.sv
// ----------------------------------------------------------------------------
// Heading unit front end
// Takes sensor requests, forms the scaled horizontal field Xh', Yh'.
// ----------------------------------------------------------------------------
module tch_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tch_req_if.sink            i_req,
    input  tch_pkg::t_q_stat   i_qstat,
    output logic               o_push,
    output tch_pkg::t_q_entry  o_entry
);
    import tch_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_PROD = 3'd5;
    localparam logic [2:0] S_COMB = 3'd6;
    localparam logic [2:0] S_PUSH = 3'd7;

    localparam int P_W = FIELD_W + AXIS_W;

    logic [2:0]               r_st, n_st;
    logic                     r_hold_v, n_hold_v;
    t_req                     r_hold;
    logic signed [FIELD_W-1:0] r_fx, r_fy, r_fz;
    logic signed [AXIS_W-1:0] r_ax, r_ay, r_az;
    logic [SQ_W-1:0]          r_sqx, r_sqy, r_sqz, r_r2;
    logic signed [P_W-1:0]    r_p1, r_p2, r_p3, r_p4;
    logic                     r_zero, r_rz;
    logic signed [HV_W-1:0]   r_p2a, r_t1, r_t2, r_t3, r_t4;
    logic signed [FIELD_W+ROOT_W:0] r_t5;
    logic [SQ_W:0]            r_rv, r_rres, r_nv, r_nres, r_bit;
    logic [ROOT_W-1:0]        r_rr, r_nn;
    t_q_entry                 r_entry;

    logic                     w_take;
    logic signed [SQ_W-1:0]   w_sqx, w_sqy, w_sqz;
    logic signed [P_W-1:0]    w_p1, w_p2, w_p3, w_p4;
    logic signed [HV_W-1:0]   w_p2a, w_t1, w_t2, w_t3, w_t4, w_p1e, w_p2ae, w_t5e;
    logic signed [FIELD_W+ROOT_W:0] w_t5;
    logic signed [SQ_W:0]     w_r2s;
    logic signed [ROOT_W:0]   w_rs, w_ns;
    t_sqs                     w_rstep, w_nstep;
    logic [SQ_W:0]            w_rrnd, w_nrnd;

    assign i_req.ready = !r_hold_v;
    assign w_take      = (r_st == S_IDLE) && r_hold_v;

    assign w_sqx = r_ax * r_ax;
    assign w_sqy = r_ay * r_ay;
    assign w_sqz = r_az * r_az;
    assign w_p1  = r_fz * r_ax;
    assign w_p2  = r_fx * r_ay;
    assign w_p3  = r_fy * r_az;
    assign w_p4  = r_fz * r_ay;
    assign w_p2a = r_p2 * r_ax;

    assign w_r2s = $signed({1'b0, r_r2});
    assign w_rs  = $signed({1'b0, r_rr});
    assign w_ns  = $signed({1'b0, r_nn});
    assign w_t1  = r_fx * w_r2s;
    assign w_t2  = r_p1 * w_rs;
    assign w_t3  = r_p3 * w_ns;
    assign w_t4  = r_p4 * w_rs;
    assign w_t5  = r_fy * w_ns;

    assign w_p1e  = r_p1;
    assign w_p2ae = r_p2a;
    assign w_t5e  = r_t5;

    assign w_rstep = sqrt_step(r_rv, r_rres, r_bit);
    assign w_nstep = sqrt_step(r_nv, r_nres, r_bit);
    assign w_rrnd  = r_rres + {{SQ_W{1'b0}}, (r_rv > r_rres)};
    assign w_nrnd  = r_nres + {{SQ_W{1'b0}}, (r_nv > r_nres)};

    always_comb begin
        n_hold_v = r_hold_v;
        if (i_req.valid && i_req.ready) begin
            n_hold_v = 1'b1;
        end else if (w_take) begin
            n_hold_v = 1'b0;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (r_hold_v) n_st = S_SQ;
            S_SQ:   n_st = S_SUM;
            S_SUM:  n_st = S_ROOT;
            S_ROOT: if (r_bit[0]) n_st = S_RND;
            S_RND:  n_st = S_PROD;
            S_PROD: n_st = S_COMB;
            S_COMB: n_st = S_PUSH;
            S_PUSH: if (!i_qstat.full) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_hold_v <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_hold.mag_x   <= i_req.mag_x;
            r_hold.mag_y   <= i_req.mag_y;
            r_hold.mag_z   <= i_req.mag_z;
            r_hold.accel_x <= i_req.accel_x;
            r_hold.accel_y <= i_req.accel_y;
            r_hold.accel_z <= i_req.accel_z;
        end
        case (r_st)
            S_IDLE: begin
                r_fx <= FIELD_W'(r_hold.mag_x);
                r_fy <= -FIELD_W'(r_hold.mag_y);
                r_fz <= -FIELD_W'(r_hold.mag_z);
                r_ax <= r_hold.accel_x;
                r_ay <= r_hold.accel_y;
                r_az <= r_hold.accel_z;
            end
            S_SQ: begin
                r_sqx  <= unsigned'(w_sqx);
                r_sqy  <= unsigned'(w_sqy);
                r_sqz  <= unsigned'(w_sqz);
                r_p1   <= w_p1;
                r_p2   <= w_p2;
                r_p3   <= w_p3;
                r_p4   <= w_p4;
                r_zero <= (r_ax == '0) && (r_ay == '0) && (r_az == '0);
            end
            S_SUM: begin
                r_r2   <= r_sqy + r_sqz;
                r_rv   <= {1'b0, r_sqy + r_sqz};
                r_nv   <= {1'b0, r_sqy + r_sqz + r_sqx};
                r_rres <= '0;
                r_nres <= '0;
                r_bit  <= (SQ_W+1)'(1) << (SQ_W - 2);
                r_p2a  <= w_p2a;
            end
            S_ROOT: begin
                r_rv   <= w_rstep.v;
                r_rres <= w_rstep.res;
                r_nv   <= w_nstep.v;
                r_nres <= w_nstep.res;
                r_bit  <= r_bit >> 2;
            end
            S_RND: begin
                r_rr <= w_rrnd[ROOT_W-1:0];
                r_nn <= w_nrnd[ROOT_W-1:0];
            end
            S_PROD: begin
                r_t1 <= w_t1;
                r_t2 <= w_t2;
                r_t3 <= w_t3;
                r_t4 <= w_t4;
                r_t5 <= w_t5;
                r_rz <= (r_rr == '0);
            end
            S_COMB: begin
                r_entry.acc_ok <= !r_zero;
                if (r_rz) begin
                    r_entry.xh <= -w_p1e;
                    r_entry.yh <= w_t5e;
                end else begin
                    r_entry.xh <= r_t1 - r_t2;
                    r_entry.yh <= r_t3 - w_p2ae - r_t4;
                end
            end
            default: ;
        endcase
    end

    assign o_push  = (r_st == S_PUSH) && !i_qstat.full;
    assign o_entry = r_entry;

endmodule

### design/tch_queue.sv
// ----------------------------------------------------------------------------
// Heading unit queue
// Two-entry queue between front end and CORDIC back end.
// ----------------------------------------------------------------------------
module tch_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tch_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output tch_pkg::t_q_entry  o_entry,
    output tch_pkg::t_q_stat   o_qstat
);
    import tch_pkg::*;

    t_q_entry   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign w_push = i_push && (r_cnt != 2'd2);
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_entry       = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

endmodule

### design/tch_back.sv
// ----------------------------------------------------------------------------
// Heading unit back end
// Normalizes Xh', Yh', runs CORDIC vectoring, scales to 1/128 degree.
// ----------------------------------------------------------------------------
module tch_back #(
    parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tch_pkg::t_q_stat   i_qstat,
    input  tch_pkg::t_q_entry  i_entry,
    output logic               o_pop,
    tch_res_if.source          o_res
);
    import tch_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [IDX_W-1:0] LAST_I = IDX_W'(NSTEPS - 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_NORM = 3'd1;
    localparam logic [2:0] B_ROT  = 3'd2;
    localparam logic [2:0] B_MAP  = 3'd3;
    localparam logic [2:0] B_MUL  = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    localparam logic [HV_W-1:0] M_HI4 = HV_W'(1) << 34;
    localparam logic [HV_W-1:0] M_HI  = HV_W'(1) << 30;
    localparam logic [HV_W-1:0] M_LO  = HV_W'(1) << 29;
    localparam logic [HV_W-1:0] M_LO4 = HV_W'(1) << 25;
    localparam logic signed [CX_W-1:0] Z_QTR = CX_W'(1) << 30;
    localparam int PR_W = ANG_W + HEAD_W;

    logic [2:0]             r_st, n_st;
    logic [HV_W-1:0]        r_ux, r_uy;
    logic                   r_sx, r_sy, r_ok, r_nz;
    logic signed [CX_W-1:0] r_x, r_y, r_z;
    logic [IDX_W-1:0]       r_i;
    logic [ANG_W-1:0]       r_ang;
    logic [PR_W-1:0]        r_prod;
    logic                   r_out_v;
    logic [HEAD_W-1:0]      r_out_h;
    logic                   r_out_hv;

    logic [HV_W-1:0]        w_ux, w_uy, w_m;
    logic                   w_xz, w_yz, w_load;
    logic signed [CX_W-1:0] w_dx, w_dy, w_at;
    logic [ANG_W-1:0]       w_a, w_ang;
    logic [PR_W:0]          w_sum;
    logic [HEAD_W-1:0]      w_h;

    assign o_pop  = (r_st == B_IDLE) && !i_qstat.empty;
    assign w_ux   = i_entry.xh[HV_W-1] ? unsigned'(-i_entry.xh) : unsigned'(i_entry.xh);
    assign w_uy   = i_entry.yh[HV_W-1] ? unsigned'(-i_entry.yh) : unsigned'(i_entry.yh);
    assign w_xz   = (i_entry.xh == '0);
    assign w_yz   = (i_entry.yh == '0);
    assign w_m    = (r_ux > r_uy) ? r_ux : r_uy;
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_at   = $signed({{(CX_W-ANG_W){1'b0}}, atan_turn(r_i)});
    assign w_load = (r_st == B_DONE) && (!r_out_v || o_res.ready);

    always_comb begin
        if (r_z < 0) begin
            w_a = '0;
        end else if (r_z > Z_QTR) begin
            w_a = ANG_W'(Z_QTR);
        end else begin
            w_a = r_z[ANG_W-1:0];
        end
        case ({r_sx, r_sy})
            2'b00:   w_ang = w_a;
            2'b10:   w_ang = (ANG_W'(1) << 31) - w_a;
            2'b11:   w_ang = (ANG_W'(1) << 31) + w_a;
            default: w_ang = '0 - w_a;
        endcase
    end

    assign w_sum = {1'b0, r_prod} + ((PR_W+1)'(1) << 31);
    assign w_h   = (w_sum[PR_W-1:ANG_W] >= HEADING_FULL) ? '0 : w_sum[PR_W-1:ANG_W];

    always_comb begin
        n_st = r_st;
        case (r_st)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    if (!i_entry.acc_ok || w_xz || w_yz) begin
                        n_st = B_MAP;
                    end else begin
                        n_st = B_NORM;
                    end
                end
            end
            B_NORM: if (w_m >= M_LO && w_m < M_HI) n_st = B_ROT;
            B_ROT:  if (r_i == LAST_I) n_st = B_MAP;
            B_MAP:  n_st = B_MUL;
            B_MUL:  n_st = B_DONE;
            B_DONE: if (w_load) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            B_IDLE: begin
                r_ux <= w_ux;
                r_uy <= w_uy;
                r_sx <= i_entry.xh[HV_W-1];
                r_sy <= i_entry.yh[HV_W-1];
                r_ok <= i_entry.acc_ok;
                r_nz <= !(w_xz && w_yz);
                r_i  <= '0;
                r_z  <= (w_xz && !w_yz) ? Z_QTR : '0;
            end
            B_NORM: begin
                if (w_m >= M_HI4) begin
                    r_ux <= r_ux >> 4;
                    r_uy <= r_uy >> 4;
                end else if (w_m >= M_HI) begin
                    r_ux <= r_ux >> 1;
                    r_uy <= r_uy >> 1;
                end else if (w_m < M_LO4) begin
                    r_ux <= r_ux << 4;
                    r_uy <= r_uy << 4;
                end else if (w_m < M_LO) begin
                    r_ux <= r_ux << 1;
                    r_uy <= r_uy << 1;
                end
                r_x <= $signed(r_ux[CX_W-1:0]);
                r_y <= $signed(r_uy[CX_W-1:0]);
                r_z <= '0;
            end
            B_ROT: begin
                if (!r_y[CX_W-1]) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end
                r_i <= r_i + IDX_W'(1);
            end
            B_MAP:  r_ang  <= w_ang;
            B_MUL:  r_prod <= r_ang * HEADING_FULL;
            default: ;
        endcase
        if (w_load) begin
            r_out_h  <= (r_ok && r_nz) ? w_h : '0;
            r_out_hv <= r_ok;
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.heading       = r_out_h;
    assign o_res.heading_valid = r_out_hv;

endmodule

### bench/tilt_compensated_heading_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt compensated heading unit testbench
// Drives directed and random magnetometer and accelerometer requests in random
// bursts, predicts each heading with an integer model of the tilt rotation and
// CORDIC, and compares every result in order while the result side stalls in randomly chosen patterns.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_unit_tb;
    import tch_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 200;

    typedef struct {
        logic [HEAD_W-1:0] heading;
        logic              heading_valid;
    } t_heading_exp;

    logic i_clk;
    logic i_rst_n;

    tch_req_if req_ch ();
    tch_res_if res_ch ();

    tilt_compensated_heading_unit #(.CORDIC_STEPS(STEPS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    t_req         pending_reqs[$];
    t_heading_exp heading_exp[$];
    int           mismatches;
    int           checked;
    int           invalid_seen;
    int           cycles;
    int           gap_left;
    int           burst_left;
    int           stall_phase;
    int           stall_mode;
    bit           stim_done;

    function automatic longint unsigned root_nearest(input longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 32;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt >>= 2;
        end
        if (v > res) res++;
        return res;
    endfunction

    function automatic logic [31:0] quadrant_angle(input longint unsigned ux,
                                                   input longint unsigned uy);
        longint unsigned m;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        m = (ux > uy) ? ux : uy;
        z = 0;
        while (m >= (64'd1 << 30)) begin
            ux >>= 1;
            uy >>= 1;
            m  >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            ux <<= 1;
            uy <<= 1;
            m  <<= 1;
        end
        x = longint'(ux);
        y = longint'(uy);
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_turn(i[IDX_W-1:0]));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_turn(i[IDX_W-1:0]));
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(1) << 30)) z = longint'(1) << 30;
        return z[31:0];
    endfunction

    function automatic t_heading_exp predict_heading(input t_req r);
        t_heading_exp    e;
        longint          fx, fy, fz, ax, ay, az, r2, n2, rr, nn, xh, yh;
        longint unsigned ux, uy, h;
        logic [31:0]     a, ang;
        fx = r.mag_x;
        fy = -longint'(r.mag_y);
        fz = -longint'(r.mag_z);
        ax = r.accel_x;
        ay = r.accel_y;
        az = r.accel_z;
        e.heading = '0;
        e.heading_valid = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) return e;
        e.heading_valid = 1'b1;
        r2 = ay * ay + az * az;
        n2 = r2 + ax * ax;
        rr = longint'(root_nearest(r2));
        nn = longint'(root_nearest(n2));
        if (rr > 0) begin
            xh = fx * r2 - fz * ax * rr;
            yh = -fx * ay * ax + fy * az * nn - fz * ay * rr;
        end else begin
            xh = -fz * ax;
            yh = fy * nn;
        end
        if (xh == 0 && yh == 0) return e;
        ux = (xh < 0) ? -xh : xh;
        uy = (yh < 0) ? -yh : yh;
        if (uy == 0) a = '0;
        else if (ux == 0) a = 32'd1 << 30;
        else a = quadrant_angle(ux, uy);
        if (xh >= 0 && yh >= 0) ang = a;
        else if (xh < 0 && yh >= 0) ang = (32'd1 << 31) - a;
        else if (xh < 0) ang = (32'd1 << 31) + a;
        else ang = 32'd0 - a;
        h = (longint'(ang) * 46080 + (64'd1 << 31)) >> 32;
        if (h >= 46080) h = 0;
        e.heading = h[HEAD_W-1:0];
        return e;
    endfunction

    function automatic t_req make_req(input int mx, my, mz, ax, ay, az);
        t_req r;
        r.mag_x   = mx[15:0];
        r.mag_y   = my[15:0];
        r.mag_z   = mz[15:0];
        r.accel_x = ax[15:0];
        r.accel_y = ay[15:0];
        r.accel_z = az[15:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_axis(input int span);
        int v;
        v = $urandom_range(2 * span) - span;
        return v[15:0];
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.mag_x   <= '0;
            req_ch.mag_y   <= '0;
            req_ch.mag_z   <= '0;
            req_ch.accel_x <= '0;
            req_ch.accel_y <= '0;
            req_ch.accel_z <= '0;
            gap_left       <= 0;
            burst_left     <= 1;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                heading_exp.push_back(predict_heading(pending_reqs.pop_front()));
            end
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                req_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                req_ch.valid   <= 1'b1;
                req_ch.mag_x   <= pending_reqs[0].mag_x;
                req_ch.mag_y   <= pending_reqs[0].mag_y;
                req_ch.mag_z   <= pending_reqs[0].mag_z;
                req_ch.accel_x <= pending_reqs[0].accel_x;
                req_ch.accel_y <= pending_reqs[0].accel_y;
                req_ch.accel_z <= pending_reqs[0].accel_z;
                if (burst_left <= 1) begin
                    burst_left <= int'($urandom_range(12, 1));
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : int'($urandom_range(40));
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_heading_exp e;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_phase  <= 0;
            stall_mode   <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (heading_exp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: heading %0d valid %0b",
                                 res_ch.heading, res_ch.heading_valid);
                end else begin
                    e = heading_exp.pop_front();
                    checked++;
                    if (!e.heading_valid) invalid_seen++;
                    if (res_ch.heading !== e.heading ||
                        res_ch.heading_valid !== e.heading_valid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: expected heading %0d valid %0b, got %0d %0b",
                                     checked, e.heading, e.heading_valid,
                                     res_ch.heading, res_ch.heading_valid);
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_phase % 256 == 255) stall_mode <= int'($urandom_range(3));
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= (stall_phase % 7) < 4;
                2: res_ch.ready <= 1'($urandom_range(1));
                default: res_ch.ready <= ($urandom_range(9) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tilt_compensated_heading_unit test failed");
            $finish;
        end
    end

    initial begin
        t_req r;
        int   kind;
        mismatches   = 0;
        checked      = 0;
        invalid_seen = 0;
        cycles       = 0;
        stim_done    = 0;
        i_rst_n      = 1'b0;
        pending_reqs.push_back(make_req(1000, 200, -300, 0, 0, 0));
        pending_reqs.push_back(make_req(-32768, -32768, -32768, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 100, -200, 16000));
        pending_reqs.push_back(make_req(1000, 500, 300, 16000, 0, 0));
        pending_reqs.push_back(make_req(-700, -1200, 900, -16000, 0, 0));
        pending_reqs.push_back(make_req(1000, 0, 0, 0, 0, 16000));
        pending_reqs.push_back(make_req(-1000, 0, 0, 0, 0, 16000));
        pending_reqs.push_back(make_req(0, 1000, 0, 0, 0, 16000));
        pending_reqs.push_back(make_req(0, -1000, 0, 0, 0, 16000));
        pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767));
        pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_reqs.push_back(make_req(32767, -32768, 32767, -32768, 32767, -32768));
        pending_reqs.push_back(make_req(-32768, 32767, -32768, 32767, -32768, 32767));
        pending_reqs.push_back(make_req(1, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(-1, -1, -1, -1, -1, -1));
        pending_reqs.push_back(make_req(300, 400, -500, 2000, -1500, 15800));
        pending_reqs.push_back(make_req(-300, 200, 500, 0, 16000, 0));
        pending_reqs.push_back(make_req(500, 500, 0, 0, -16000, 0));
        pending_reqs.push_back(make_req(0, 0, 1000, -32768, 0, 0));
        for (int n = 0; n < 700; n++) begin
            kind = int'($urandom_range(9));
            r.mag_x = rand_axis(4000);
            r.mag_y = rand_axis(4000);
            r.mag_z = rand_axis(4000);
            r.accel_x = rand_axis(3000);
            r.accel_y = rand_axis(3000);
            r.accel_z = 16'(16384 + int'($urandom_range(2000)) - 1000);
            if (kind == 0) begin
                r = t_req'({$urandom, $urandom, $urandom});
            end else if (kind == 1) begin
                r.accel_x = 16'($urandom);
                r.accel_y = 16'($urandom);
                r.accel_z = 16'($urandom);
                r.mag_x   = 16'($urandom);
                r.mag_y   = 16'($urandom);
                r.mag_z   = 16'($urandom);
            end else if (kind == 2) begin
                r.accel_z = -r.accel_z;
            end else if (kind == 3 && $urandom_range(3) == 0) begin
                r.accel_x = '0;
                r.accel_y = '0;
                r.accel_z = '0;
            end else if (kind == 4 && $urandom_range(3) == 0) begin
                r.accel_y = '0;
                r.accel_z = '0;
            end
            pending_reqs.push_back(r);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && heading_exp.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        $display("checked %0d headings, %0d with a zero accelerometer", checked,
                 invalid_seen);
        if (mismatches == 0 && heading_exp.size() == 0) begin
            $display("tilt_compensated_heading_unit test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tilt_compensated_heading_unit test failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/tch_pkg.sv
design/tch_if.sv
design/tch_front.sv
design/tch_queue.sv
design/tch_back.sv
design/tilt_compensated_heading_unit.sv
bench/tilt_compensated_heading_unit_tb.sv
